FILE: src/edd16_pkg.sv
`timescale 1ns / 1ps
// shared types, register codes and error arithmetic for the 16-level dither
package edd16_pkg;

  localparam int ERR_W = 10;
  localparam int CFG_W = 11;

  typedef logic signed [ERR_W-1:0] err_t;

  // register index codes of the configuration port
  localparam logic [0:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_IMAGE_HEIGHT = 1'b1;

  // weights of the four error shares
  localparam logic [2:0] W_RIGHT = 3'd7;
  localparam logic [2:0] W_DL    = 3'd3;
  localparam logic [2:0] W_DOWN  = 3'd5;
  localparam logic [2:0] W_DR    = 3'd1;

  // position of a pixel within the frame, worked out by the front
  typedef struct packed {
    logic last_col;
    logic last_row;
    logic first_row;
  } pos_flags_t;

  function automatic err_t sat_err(input logic signed [11:0] v);
    err_t r;
    if (v > 12'sd511) begin
      r = 10'sd511;
    end else if (v < -12'sd512) begin
      r = -10'sd512;
    end else begin
      r = $signed(v[9:0]);
    end
    return r;
  endfunction

  function automatic err_t add_sat(input err_t a, input err_t b);
    logic signed [11:0] s;
    s = $signed({{2{a[9]}}, a}) + $signed({{2{b[9]}}, b});
    return sat_err(s);
  endfunction

  // (e * k) / 16 truncated toward zero
  function automatic err_t share(input err_t e, input logic [2:0] k);
    logic signed [10:0] ex;
    logic [10:0]        mag;
    logic [13:0]        prod;
    logic [9:0]         q;
    err_t               r;
    ex   = {e[9], e};
    mag  = e[9] ? 11'(-ex) : 11'(ex);
    prod = 14'(mag) * 14'(k);
    q    = prod[13:4];
    r    = e[9] ? $signed(10'(~q + 10'd1)) : $signed(q);
    return r;
  endfunction

endpackage

FILE: src/edd16_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with registered read
module edd16_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/edd16_queue.sv
`timescale 1ns / 1ps
// two-entry queue between the pixel front and the error back
module edd16_queue #(
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output logic [DW-1:0] data_o
);

  logic [DW-1:0] slot_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: src/edd16_front.sv
`timescale 1ns / 1ps
// pixel front: frame registers, raster position counters and request intake
module edd16_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_index_i,
  input  logic [edd16_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   grey_in_i,
  input  logic                         hold_i,
  input  logic                         queue_full_i,
  output logic                         push_o,
  output logic [7:0]                   push_grey_o,
  output logic [$clog2(MAX_WIDTH)-1:0] push_x_o,
  output edd16_pkg::pos_flags_t        push_flags_o
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int MW = (AW > HW) ? AW : HW;
  localparam int EW = (MW + 1 > edd16_pkg::CFG_W) ? MW + 1 : edd16_pkg::CFG_W;

  logic [edd16_pkg::CFG_W-1:0] width_q, height_q;
  logic [AW-1:0]               col_q;
  logic [HW-1:0]               row_q;
  logic [EW-1:0]               w_ext, h_ext, w_eff, h_eff;
  logic                        last_col, last_row, accept;

  assign w_ext = EW'(width_q);
  assign h_ext = EW'(height_q);

  always_comb begin
    if (w_ext == '0) begin
      w_eff = EW'(1);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext == '0) begin
      h_eff = EW'(1);
    end else if (h_ext > EW'(MAX_HEIGHT)) begin
      h_eff = EW'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
  end

  // at or past the end also covers a register that shrank mid-frame
  assign last_col = (EW'(col_q) >= (w_eff - EW'(1)));
  assign last_row = (EW'(row_q) >= (h_eff - EW'(1)));

  assign in_stall_o = queue_full_i || hold_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign push_o                 = accept;
  assign push_grey_o            = grey_in_i;
  assign push_x_o               = col_q;
  assign push_flags_o.last_col  = last_col;
  assign push_flags_o.last_row  = last_row;
  assign push_flags_o.first_row = (row_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd1024;
      height_q <= 11'd1024;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          edd16_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
          edd16_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : HW'(row_q + 1'b1);
        end else begin
          col_q <= AW'(col_q + 1'b1);
        end
      end
    end
  end

endmodule

FILE: src/edd16_back.sv
`timescale 1ns / 1ps
// error back: line buffer read, quantize and error spread, result register
module edd16_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  output logic                         q_pop_o,
  input  logic [7:0]                   q_grey_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_x_i,
  input  edd16_pkg::pos_flags_t        q_flags_i,
  output logic                         clr_busy_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   dithered_out_o,
  output logic                         row_end_o,
  output logic                         frame_end_o
);

  localparam int AW = $clog2(MAX_WIDTH);

  // clearing pass over the line buffer after reset
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  // read stage
  logic                  r_valid_q;
  logic [7:0]            r_grey_q;
  logic [AW-1:0]         r_x_q;
  edd16_pkg::pos_flags_t r_flags_q;
  logic                  byp_valid_q, byp_valid_d;
  edd16_pkg::err_t       byp_data_q, byp_data_d;

  // carried error state
  edd16_pkg::err_t rc_q, rc_d, diag_q, diag_d, below_q, below_d;

  // last-column share waiting for a free write slot
  logic            tail_valid_q, tail_valid_d;
  logic [AW-1:0]   tail_addr_q;
  edd16_pkg::err_t tail_data_q;

  // result register
  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic       out_row_end_q, out_frame_end_q;

  logic            e_fire, e_wr, e_tail, flush, has_below;
  logic [AW-1:0]   e_wr_addr;
  edd16_pkg::err_t ram_rdata, below_in, err, s7, s3, s5, s1, val3, below_new;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  edd16_pkg::err_t ram_wdata;
  logic signed [11:0] sum;
  logic [3:0]         level;

  assign clr_busy_o = clr_busy_q;

  assign e_fire  = r_valid_q && (!out_valid_q || !out_stall_i);
  assign q_pop_o = q_valid_i && !clr_busy_q && (!r_valid_q || e_fire);

  assign has_below = !r_flags_q.last_row;
  assign e_wr      = e_fire && has_below && (r_x_q != '0);
  assign e_tail    = e_fire && has_below && r_flags_q.last_col;
  assign e_wr_addr = AW'(r_x_q - 1'b1);

  // first row does not see the line buffer
  assign below_in = r_flags_q.first_row ? '0 : (byp_valid_q ? byp_data_q : ram_rdata);

  assign sum = $signed({4'b0000, r_grey_q}) + $signed({{2{rc_q[9]}}, rc_q})
             + $signed({{2{below_in[9]}}, below_in});

  always_comb begin
    if (sum[11]) begin
      level = 4'd0;
    end else if (sum[10:8] != 3'd0) begin
      level = 4'd15;
    end else begin
      level = sum[7:4];
    end
  end

  assign err       = edd16_pkg::sat_err(sum - $signed({4'b0000, level, 4'b0000}));
  assign s7        = edd16_pkg::share(err, edd16_pkg::W_RIGHT);
  assign s3        = edd16_pkg::share(err, edd16_pkg::W_DL);
  assign s5        = edd16_pkg::share(err, edd16_pkg::W_DOWN);
  assign s1        = edd16_pkg::share(err, edd16_pkg::W_DR);
  assign val3      = edd16_pkg::add_sat(below_q, s3);
  assign below_new = edd16_pkg::add_sat(diag_q, s5);

  always_comb begin
    rc_d    = rc_q;
    diag_d  = diag_q;
    below_d = below_q;
    if (e_fire) begin
      if (has_below) begin
        below_d = below_new;
        diag_d  = r_flags_q.last_col ? '0 : s1;
      end
      rc_d = r_flags_q.last_col ? '0 : s7;
      if (r_flags_q.last_col) begin
        diag_d  = '0;
        below_d = '0;
      end
    end
  end

  // one ram write port: clearing, then the down-left share, then the tail
  assign flush = tail_valid_q && !clr_busy_q && !e_wr;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail_addr_q;
    ram_wdata = tail_data_q;
    if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else if (e_wr) begin
      ram_we    = 1'b1;
      ram_waddr = e_wr_addr;
      ram_wdata = val3;
    end else if (flush) begin
      ram_we = 1'b1;
    end
  end

  assign tail_valid_d = e_tail ? 1'b1 : (flush ? 1'b0 : tail_valid_q);

  // the ram returns pre-write data, so writes in flight are forwarded
  always_comb begin
    byp_valid_d = byp_valid_q;
    byp_data_d  = byp_data_q;
    if (q_pop_o) begin
      byp_valid_d = 1'b1;
      if (e_wr && (e_wr_addr == q_x_i)) begin
        byp_data_d = val3;
      end else if (e_tail && (r_x_q == q_x_i)) begin
        byp_data_d = below_new;
      end else if (tail_valid_q && (tail_addr_q == q_x_i)) begin
        byp_data_d = tail_data_q;
      end else begin
        byp_valid_d = 1'b0;
      end
    end
  end

  edd16_ram #(
    .WIDTH (edd16_pkg::ERR_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (q_pop_o),
    .raddr_i (q_x_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q   <= 1'b1;
      clr_addr_q   <= '0;
      r_valid_q    <= 1'b0;
      byp_valid_q  <= 1'b0;
      rc_q         <= '0;
      diag_q       <= '0;
      below_q      <= '0;
      tail_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= AW'(clr_addr_q + 1'b1);
        if (clr_addr_q == AW'(MAX_WIDTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      r_valid_q    <= q_pop_o ? 1'b1 : (e_fire ? 1'b0 : r_valid_q);
      byp_valid_q  <= byp_valid_d;
      rc_q         <= rc_d;
      diag_q       <= diag_d;
      below_q      <= below_d;
      tail_valid_q <= tail_valid_d;
      out_valid_q  <= e_fire || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      r_grey_q  <= q_grey_i;
      r_x_q     <= q_x_i;
      r_flags_q <= q_flags_i;
    end
    byp_data_q <= byp_data_d;
    if (e_tail) begin
      tail_addr_q <= r_x_q;
      tail_data_q <= below_new;
    end
    if (e_fire) begin
      out_data_q      <= {level, 4'b0000};
      out_row_end_q   <= r_flags_q.last_col;
      out_frame_end_q <= r_flags_q.last_col && r_flags_q.last_row;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dithered_out_o = out_data_q;
  assign row_end_o      = out_row_end_q;
  assign frame_end_o    = out_frame_end_q;

endmodule

FILE: src/error_diffusion_dither_16_level.sv
`timescale 1ns / 1ps
// top level of the 16-level error diffusion dither
//
//   channel   signals                                       direction
//   config    cfg_we_i cfg_index_i cfg_data_i               in, write only
//   pixel     in_valid_i in_stall_o grey_in_i               in
//   result    out_valid_o out_stall_i dithered_out_o
//             row_end_o frame_end_o                         out
//
// one pixel per clock sustained unless stalled or clearing, set by the right-carry
// loop in the error stage; a pixel goes through queue, read stage, result register.
// after reset the line buffer is cleared with in_stall_o high.
// a two-entry queue parts the front from the back, and the result register
// takes a new pixel in the same cycle its held result is taken.
module error_diffusion_dither_16_level #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_index_i,
  input  logic [edd16_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  grey_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  dithered_out_o,
  output logic                        row_end_o,
  output logic                        frame_end_o
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int FW = $bits(edd16_pkg::pos_flags_t);
  localparam int DW = 8 + AW + FW;

  logic                  push, q_full, q_valid, q_pop, clr_busy;
  logic [7:0]            push_grey;
  logic [AW-1:0]         push_x;
  edd16_pkg::pos_flags_t push_flags, q_flags;
  logic [DW-1:0]         q_din, q_dout;

  edd16_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .grey_in_i    (grey_in_i),
    .hold_i       (clr_busy),
    .queue_full_i (q_full),
    .push_o       (push),
    .push_grey_o  (push_grey),
    .push_x_o     (push_x),
    .push_flags_o (push_flags)
  );

  assign q_din = {push_grey, push_x, push_flags};

  edd16_queue #(
    .DW (DW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_din),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_dout)
  );

  assign q_flags = q_dout[FW-1:0];

  edd16_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .q_grey_i       (q_dout[DW-1 -: 8]),
    .q_x_i          (q_dout[FW +: AW]),
    .q_flags_i      (q_flags),
    .clr_busy_o     (clr_busy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .dithered_out_o (dithered_out_o),
    .row_end_o      (row_end_o),
    .frame_end_o    (frame_end_o)
  );

endmodule
